// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the trapezoidal profile RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TPE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TPE_ASSERT_NEVER(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define TPE_ASSERT(lbl, clk, rst_n, prop, msg)
`define TPE_ASSERT_NEVER(lbl, clk, rst_n, prop, msg)
`endif
`endif

// ===== hdl/tpe_pkg.sv =====
// Shared types and constants of the trapezoidal profile evaluator.
package tpe_pkg;

  localparam int FRAC_BITS = 16;
  localparam int REG_W     = 31;
  localparam int TIME_W    = 32;
  localparam int DR_W      = 30;
  localparam int TR_W      = 48;
  localparam int TOT_W     = 50;

  typedef enum logic [1:0] {
    CFG_DIST = 2'd0,
    CFG_VEL  = 2'd1,
    CFG_ACC  = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    RG_END = 2'd0,
    RG_ACC = 2'd1,
    RG_CRU = 2'd2,
    RG_DEC = 2'd3
  } region_e;

  typedef struct packed {
    logic [REG_W-1:0] target;
    logic [REG_W-1:0] acc_lim;
    logic [REG_W-1:0] vp;
    logic [DR_W-1:0]  dr;
    logic [REG_W-1:0] dc;
    logic [TR_W-1:0]  tr;
    logic [TOT_W-1:0] trtc;
    logic [TOT_W-1:0] total;
  } derived_t;

endpackage

// ===== hdl/tpe_derive.sv =====
// Configuration registers and sequential derivation of the profile timing.
`include "assert_macros.svh"
module tpe_derive (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_idx_i,
  input  logic [30:0]             cfg_wdata_i,
  output logic                    busy_o,
  output tpe_pkg::derived_t       deriv_o
);
  import tpe_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_MUL  = 8'b0000_0010,
    ST_CHK  = 8'b0000_0100,
    ST_SQRT = 8'b0000_1000,
    ST_DTR  = 8'b0001_0000,
    ST_DDR  = 8'b0010_0000,
    ST_DTC  = 8'b0100_0000,
    ST_SUM  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic [REG_W-1:0] dist_q, dist_d, vel_q, vel_d, acc_q, acc_d;
  logic [61:0] vv_q, vv_d, ad_q, ad_d;
  logic        tri_q, tri_d;
  logic [REG_W-1:0] vp_q, vp_d, dc_q, dc_d;
  logic [DR_W-1:0]  dr_q, dr_d;
  logic [TR_W-1:0]  tr_q, tr_d, tc_q, tc_d;
  logic [TOT_W-1:0] trtc_q, trtc_d, total_q, total_d;
  logic [63:0] sx_q, sx_d, sres_q, sres_d, sbit_q, sbit_d;
  logic [32:0] rem_q, rem_d;
  logic [63:0] quo_q, quo_d;
  logic [31:0] dvs_q, dvs_d;
  logic [5:0]  cnt_q, cnt_d;

  logic [32:0] rem_sh, rem_n;
  logic        div_ge, div_done;
  logic [63:0] quo_n;
  logic [63:0] s_sum, sx_n, sres_n;
  logic        s_ge;
  logic [REG_W-1:0] dc_new;

  assign rem_sh   = {rem_q[31:0], quo_q[63]};
  assign div_ge   = rem_sh >= {1'b0, dvs_q};
  assign rem_n    = div_ge ? rem_sh - {1'b0, dvs_q} : rem_sh;
  assign quo_n    = {quo_q[62:0], div_ge};
  assign div_done = (cnt_q == 6'd63);

  assign s_sum  = sres_q + sbit_q;
  assign s_ge   = sx_q >= s_sum;
  assign sx_n   = s_ge ? sx_q - s_sum : sx_q;
  assign sres_n = s_ge ? (sres_q >> 1) + sbit_q : sres_q >> 1;

  assign dc_new = dist_q - {quo_n[DR_W-1:0], 1'b0};

  always_comb begin
    state_d = state_q;
    dist_d = dist_q; vel_d = vel_q; acc_d = acc_q;
    vv_d = vv_q; ad_d = ad_q; tri_d = tri_q;
    vp_d = vp_q; dr_d = dr_q; dc_d = dc_q; tr_d = tr_q; tc_d = tc_q;
    trtc_d = trtc_q; total_d = total_q;
    sx_d = sx_q; sres_d = sres_q; sbit_d = sbit_q;
    rem_d = rem_q; quo_d = quo_q; dvs_d = dvs_q; cnt_d = cnt_q;
    case (state_q)
      ST_IDLE: begin
      end
      ST_MUL: begin
        vv_d = 62'(vel_q) * 62'(vel_q);
        ad_d = 62'(acc_q) * 62'(dist_q);
        state_d = ST_CHK;
      end
      ST_CHK: begin
        if (vel_q == '0 || acc_q == '0) begin
          vp_d = '0; dr_d = '0; dc_d = '0; tr_d = '0; tc_d = '0;
          trtc_d = '0; total_d = '0;
          state_d = ST_IDLE;
        end else if (vv_q > ad_q) begin
          tri_d = 1'b1;
          sx_d = {2'b0, ad_q};
          sres_d = '0;
          sbit_d = 64'h4000_0000_0000_0000;
          state_d = ST_SQRT;
        end else begin
          tri_d = 1'b0;
          vp_d = vel_q;
          quo_d = {17'b0, vel_q, 16'b0};
          rem_d = '0; dvs_d = {1'b0, acc_q}; cnt_d = '0;
          state_d = ST_DTR;
        end
      end
      ST_SQRT: begin
        sx_d = sx_n; sres_d = sres_n; sbit_d = sbit_q >> 2;
        if (sbit_q[0]) begin
          vp_d = sres_n[REG_W-1:0];
          quo_d = {17'b0, sres_n[REG_W-1:0], 16'b0};
          rem_d = '0; dvs_d = {1'b0, acc_q}; cnt_d = '0;
          state_d = ST_DTR;
        end
      end
      ST_DTR: begin
        rem_d = rem_n; quo_d = quo_n; cnt_d = cnt_q + 6'd1;
        if (div_done) begin
          tr_d = quo_n[TR_W-1:0];
          if (tri_q) begin
            dr_d = dist_q[REG_W-1:1];
            dc_d = '0; tc_d = '0;
            state_d = ST_SUM;
          end else begin
            quo_d = {2'b0, vv_q};
            rem_d = '0; dvs_d = {acc_q, 1'b0}; cnt_d = '0;
            state_d = ST_DDR;
          end
        end
      end
      ST_DDR: begin
        rem_d = rem_n; quo_d = quo_n; cnt_d = cnt_q + 6'd1;
        if (div_done) begin
          dr_d = quo_n[DR_W-1:0];
          dc_d = dc_new;
          quo_d = {17'b0, dc_new, 16'b0};
          rem_d = '0; dvs_d = {1'b0, vel_q}; cnt_d = '0;
          state_d = ST_DTC;
        end
      end
      ST_DTC: begin
        rem_d = rem_n; quo_d = quo_n; cnt_d = cnt_q + 6'd1;
        if (div_done) begin
          tc_d = quo_n[TR_W-1:0];
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        trtc_d  = TOT_W'(tr_q) + TOT_W'(tc_q);
        total_d = {1'b0, tr_q, 1'b0} + TOT_W'(tc_q);
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DIST: dist_d = cfg_wdata_i;
        CFG_VEL:  vel_d  = cfg_wdata_i;
        CFG_ACC:  acc_d  = cfg_wdata_i;
        default: begin
        end
      endcase
      state_d = ST_MUL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_MUL;
      dist_q  <= '0;
      vel_q   <= 31'd65536;
      acc_q   <= 31'd65536;
    end else begin
      state_q <= state_d;
      dist_q  <= dist_d;
      vel_q   <= vel_d;
      acc_q   <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vv_q <= vv_d; ad_q <= ad_d; tri_q <= tri_d;
    vp_q <= vp_d; dr_q <= dr_d; dc_q <= dc_d; tr_q <= tr_d; tc_q <= tc_d;
    trtc_q <= trtc_d; total_q <= total_d;
    sx_q <= sx_d; sres_q <= sres_d; sbit_q <= sbit_d;
    rem_q <= rem_d; quo_q <= quo_d; dvs_q <= dvs_d; cnt_q <= cnt_d;
  end

  assign busy_o          = (state_q != ST_IDLE);
  assign deriv_o.target  = dist_q;
  assign deriv_o.acc_lim = acc_q;
  assign deriv_o.vp      = vp_q;
  assign deriv_o.dr      = dr_q;
  assign deriv_o.dc      = dc_q;
  assign deriv_o.tr      = tr_q;
  assign deriv_o.trtc    = trtc_q;
  assign deriv_o.total   = total_q;

  `TPE_ASSERT(a_wr_busy, clk_i, rst_ni, cfg_we_i |=> busy_o, "write did not restart derivation")
  `TPE_ASSERT(a_trtc, clk_i, rst_ni, !busy_o |-> trtc_q == TOT_W'(tr_q) + TOT_W'(tc_q),
    "ramp plus cruise time mismatch")
  `TPE_ASSERT(a_total, clk_i, rst_ni,
    !busy_o |-> total_q == {1'b0, tr_q, 1'b0} + TOT_W'(tc_q), "total time mismatch")
endmodule

// ===== hdl/tpe_eval.sv =====
// Four stage evaluation pipeline: region select, products, square term, output.
`include "assert_macros.svh"
module tpe_eval (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  tpe_pkg::derived_t       deriv_i,
  input  logic                    in_valid_i,
  input  logic [31:0]             in_time_i,
  input  logic                    out_ready_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  output logic [30:0]             pos_o,
  output logic [30:0]             vel_o,
  output logic [31:0]             acc_o,
  output logic [31:0]             total_o
);
  import tpe_pkg::*;

  logic en;
  logic v1_q, v2_q, v3_q, v4_q;
  region_e rg1_q, rg2_q, rg3_q, rg1_d;
  logic [TIME_W-1:0] i1_q, i2_q, i1_d;
  logic [31:0] w2_q, w3_q;
  logic [46:0] vpi2_q, vpi3_q, wi3_q;
  logic [62:0] prod_a, prod_v;
  logic [63:0] prod_w;
  logic [TOT_W-1:0] t_ext;
  logic [30:0] pos_d, vel_d, pos_q, vel_q;
  logic [31:0] acc_d, acc_q, total_q;
  logic [47:0] up, cru;

  assign en = ~v4_q | out_ready_i;
  assign in_ready_o = en;
  assign t_ext = TOT_W'(in_time_i);

  always_comb begin
    rg1_d = RG_END;
    i1_d  = in_time_i;
    if (t_ext >= deriv_i.total) begin
      rg1_d = RG_END;
    end else if (TOT_W'(deriv_i.tr) >= t_ext && deriv_i.tr != '0) begin
      rg1_d = RG_ACC;
    end else if (t_ext < deriv_i.trtc) begin
      rg1_d = RG_CRU;
      i1_d  = in_time_i - deriv_i.tr[TIME_W-1:0];
    end else begin
      rg1_d = RG_DEC;
      i1_d  = in_time_i - deriv_i.trtc[TIME_W-1:0];
    end
  end

  assign prod_a = 63'(deriv_i.acc_lim) * 63'(i1_q);
  assign prod_v = 63'(deriv_i.vp) * 63'(i1_q);
  assign prod_w = 64'(w2_q) * 64'(i2_q);

  assign cru = 48'(deriv_i.dr) + 48'(vpi3_q);
  assign up  = 48'(deriv_i.dc) + 48'(deriv_i.dr) + 48'(vpi3_q);

  always_comb begin
    pos_d = deriv_i.target;
    vel_d = '0;
    acc_d = '0;
    case (rg3_q)
      RG_END: begin
      end
      RG_ACC: begin
        vel_d = w3_q[30:0];
        pos_d = (wi3_q > 47'h7FFF_FFFF) ? 31'h7FFF_FFFF : wi3_q[30:0];
        acc_d = {1'b0, deriv_i.acc_lim};
      end
      RG_CRU: begin
        vel_d = deriv_i.vp;
        pos_d = (cru > 48'h7FFF_FFFF) ? 31'h7FFF_FFFF : cru[30:0];
      end
      RG_DEC: begin
        vel_d = (w3_q > 32'(deriv_i.vp)) ? '0 : deriv_i.vp - w3_q[30:0];
        if (up <= 48'(wi3_q)) begin
          pos_d = '0;
        end else if (up - 48'(wi3_q) > 48'h7FFF_FFFF) begin
          pos_d = 31'h7FFF_FFFF;
        end else begin
          pos_d = 31'(up - 48'(wi3_q));
        end
        acc_d = 32'd0 - {1'b0, deriv_i.acc_lim};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rg1_q  <= rg1_d;
      i1_q   <= i1_d;
      rg2_q  <= rg1_q;
      i2_q   <= i1_q;
      w2_q   <= prod_a[47:16];
      vpi2_q <= prod_v[62:16];
      rg3_q  <= rg2_q;
      w3_q   <= w2_q;
      vpi3_q <= vpi2_q;
      wi3_q  <= prod_w[63:17];
      pos_q  <= pos_d;
      vel_q  <= vel_d;
      acc_q  <= acc_d;
      total_q <= (deriv_i.total > TOT_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                 : deriv_i.total[31:0];
    end
  end

  assign out_valid_o = v4_q;
  assign pos_o   = pos_q;
  assign vel_o   = vel_q;
  assign acc_o   = acc_q;
  assign total_o = total_q;

  `TPE_ASSERT(a_hold, clk_i, rst_ni, !en |=> $stable(v1_q) && $stable(v3_q),
    "pipeline moved while stalled")
  `TPE_ASSERT(a_acc_i, clk_i, rst_ni, v1_q && rg1_q == RG_ACC |-> TR_W'(i1_q) <= deriv_i.tr,
    "ramp sample beyond ramp time")
  `TPE_ASSERT(a_w_bound, clk_i, rst_ni,
    v3_q && (rg3_q == RG_ACC || rg3_q == RG_DEC) |-> w3_q <= 32'(deriv_i.vp),
    "ramp velocity above peak")
endmodule

// ===== hdl/trapezoidal_profile_eval.sv =====
// Trapezoidal velocity profile evaluator top level.
// Write target_distance, velocity_limit and acceleration_limit (indexes 0, 1, 2)
// on the cfg port while no beats are in flight. Each write restarts the timing
// derivation: a product step and a compare step, then either a 32-step square
// root and one 64-step division (triangular moves) or three 64-step
// shift-subtract divisions, then a sum step; a zero limit ends after the
// compare step. s_axis_tready stays low during that time and after reset, which
// runs the same derivation on the reset values.
// Once derived, each s_axis beat carries one query time and yields one m_axis
// beat with position, velocity, acceleration and total duration. One beat per
// cycle is sustained; every stage advances whenever the output register is
// empty or being read.
// When the receiver holds m_axis_tready low with a result waiting, the whole
// pipeline freezes and s_axis_tready drops; nothing is lost or repeated. Reset
// clears all valid bits and returns the registers to distance 0, limits 1.0.
module trapezoidal_profile_eval (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [30:0]   cfg_wdata_i,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [31:0]   s_axis_tdata,   // [31:0] query_time
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [127:0]  m_axis_tdata    // position, velocity, acceleration, total_duration
);
  import tpe_pkg::*;

  derived_t    deriv;
  logic        busy;
  logic        ev_ready;
  logic [30:0] pos, vel;
  logic [31:0] acc, total;

  tpe_derive u_derive (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .busy_o     (busy),
    .deriv_o    (deriv)
  );

  tpe_eval u_eval (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .deriv_i    (deriv),
    .in_valid_i (s_axis_tvalid & ~busy),
    .in_time_i  (s_axis_tdata),
    .out_ready_i(m_axis_tready),
    .in_ready_o (ev_ready),
    .out_valid_o(m_axis_tvalid),
    .pos_o      (pos),
    .vel_o      (vel),
    .acc_o      (acc),
    .total_o    (total)
  );

  assign s_axis_tready = ev_ready & ~busy;
  assign m_axis_tdata  = {2'b00, total, acc, vel, pos};
endmodule

// ===== bench/tb_trapezoidal_profile_eval.sv =====
// Self-checking bench for the trapezoidal profile evaluator: directed table, then random phases.
`timescale 1ns / 100ps

module tb_trapezoidal_profile_eval;
  import tpe_pkg::*;

  localparam logic [1:0]  CFG_BAD    = 2'd3;
  localparam logic [63:0] POS_MAX    = 64'h7FFF_FFFF;
  localparam logic [63:0] DUR_MAX    = 64'hFFFF_FFFF;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          N_PHASES   = 10;
  localparam int          PHASE_ITEMS = 95;
  localparam int          N_DIR      = 25;

  typedef struct packed {
    logic [31:0] total_duration;
    logic [31:0] acceleration;
    logic [30:0] velocity;
    logic [30:0] position;
  } profile_t;

  typedef struct {
    bit          is_cfg;
    logic [1:0]  idx;
    logic [31:0] val;
    bit          typed;
    profile_t    want;
  } dir_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         cfg_we_i;
  logic [1:0]   cfg_idx_i;
  logic [30:0]  cfg_wdata_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata;   // [31:0] query_time
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [127:0] m_axis_tdata;   // [30:0] position, [61:31] velocity,
                                // [93:62] acceleration, [125:94] total_duration

  logic [63:0] dist_r, vlim_r, alim_r;
  profile_t    pending_q[$];
  profile_t    typed_want;
  bit          use_typed;
  int          fail_cnt = 0;
  int          cycle_cnt = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  dir_row_t    dir_tab[N_DIR];

  trapezoidal_profile_eval DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [63:0] floor_sqrt(logic [63:0] x);
    logic [63:0] res, cand;
    res = 0;
    for (int b = 31; b >= 0; b--) begin
      cand = res | (64'd1 << b);
      if (cand * cand <= x) res = cand;
    end
    return res;
  endfunction

  function automatic profile_t eval_profile(logic [63:0] t);
    logic [63:0] d, v, a, vp, tr, dr, dc, tc, total, w, i, up, down, pos, vel, acc;
    profile_t r;
    d = dist_r;
    v = vlim_r;
    a = alim_r;
    if (v == 0 || a == 0) begin
      r.position = d[30:0];
      r.velocity = '0;
      r.acceleration = '0;
      r.total_duration = '0;
      return r;
    end
    if (v * v > a * d) begin
      vp = floor_sqrt(a * d);
      tr = (vp << FRAC_BITS) / a;
      dr = d >> 1;
      dc = 0;
      tc = 0;
    end else begin
      vp = v;
      tr = (v << FRAC_BITS) / a;
      dr = (v * v) / (2 * a);
      dc = d - 2 * dr;
      tc = (dc << FRAC_BITS) / v;
    end
    total = 2 * tr + tc;
    if (t >= total) begin
      pos = d;
      vel = 0;
      acc = 0;
    end else if (t <= tr && tr != 0) begin
      w = (a * t) >> FRAC_BITS;
      vel = w;
      pos = (w * t) >> (FRAC_BITS + 1);
      acc = a;
    end else if (t < tr + tc) begin
      i = t - tr;
      vel = vp;
      pos = dr + ((vp * i) >> FRAC_BITS);
      acc = 0;
    end else begin
      i = t - tr - tc;
      w = (a * i) >> FRAC_BITS;
      up = dc + dr + ((vp * i) >> FRAC_BITS);
      down = (w * i) >> (FRAC_BITS + 1);
      vel = (w > vp) ? 0 : vp - w;
      pos = (up > down) ? up - down : 0;
      acc = 64'd0 - a;
    end
    if (pos > POS_MAX) pos = POS_MAX;
    r.position = pos[30:0];
    r.velocity = vel[30:0];
    r.acceleration = acc[31:0];
    r.total_duration = (total > DUR_MAX) ? 32'hFFFF_FFFF : total[31:0];
    return r;
  endfunction

  function automatic dir_row_t mk_row(bit is_cfg, logic [1:0] idx, logic [31:0] val,
                                      bit typed, logic [63:0] p, logic [63:0] v,
                                      logic [63:0] a, logic [63:0] dur);
    dir_row_t r;
    r.is_cfg = is_cfg;
    r.idx = idx;
    r.val = val;
    r.typed = typed;
    r.want.position = p[30:0];
    r.want.velocity = v[30:0];
    r.want.acceleration = a[31:0];
    r.want.total_duration = dur[31:0];
    return r;
  endfunction

  function automatic logic [30:0] pick_reg(bit allow_zero);
    logic [31:0] x;
    if (allow_zero && $urandom_range(0, 11) == 0) return '0;
    case ($urandom_range(0, 5))
      0: x = $urandom_range(1, 16) << 16;
      1: x = $urandom & 32'h7FFF_FFFF;
      2: x = 32'h7FFF_FFFF;
      3: x = 32'd1;
      4: x = $urandom_range(1, 65535);
      default: x = $urandom_range(32'h1_0000, 32'h100_0000);
    endcase
    return x[30:0];
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val[30:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_DIST: dist_r = {33'd0, val[30:0]};
      CFG_VEL:  vlim_r = {33'd0, val[30:0]};
      CFG_ACC:  alim_r = {33'd0, val[30:0]};
      default: ;
    endcase
  endtask

  task automatic send_query(logic [31:0] t);
    if (!calm && $urandom_range(0, 99) < 33) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tdata <= t;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_q.push_back(use_typed ? typed_want : eval_profile({32'd0, t}));
  endtask

  task automatic check_beat();
    profile_t got, want;
    got = m_axis_tdata[125:0];
    if (pending_q.size() == 0) begin
      $error("unexpected result beat %h", m_axis_tdata);
      fail_cnt++;
      return;
    end
    want = pending_q.pop_front();
    if (got.position !== want.position) begin
      $error("position: expected %0d, got %0d", want.position, got.position);
      fail_cnt++;
    end
    if (got.velocity !== want.velocity) begin
      $error("velocity: expected %0d, got %0d", want.velocity, got.velocity);
      fail_cnt++;
    end
    if (got.acceleration !== want.acceleration) begin
      $error("acceleration: expected %h, got %h", want.acceleration, got.acceleration);
      fail_cnt++;
    end
    if (got.total_duration !== want.total_duration) begin
      $error("total_duration: expected %h, got %h", want.total_duration,
             got.total_duration);
      fail_cnt++;
    end
  endtask

  initial begin
    int hold_cnt;
    hold_cnt = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) check_beat();
      if (hold_req && !hold_done && hold_cnt == 0) begin
        hold_cnt = 300;
        hold_done = 1'b1;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 33);
      end
    end
  end

  initial begin
    logic [63:0] span;
    logic [31:0] t;
    profile_t    prof;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= CFG_DIST;
    cfg_wdata_i <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    dist_r = 0;
    vlim_r = 65536;
    alim_r = 65536;
    use_typed = 1'b0;

    dir_tab[0]  = mk_row(0, CFG_DIST, 32'd0, 1, 0, 0, 0, 0);
    dir_tab[1]  = mk_row(0, CFG_DIST, 32'hFFFF_FFFF, 1, 0, 0, 0, 0);
    dir_tab[2]  = mk_row(1, CFG_DIST, 32'd655360, 0, 0, 0, 0, 0);
    dir_tab[3]  = mk_row(0, CFG_DIST, 32'd0, 1, 0, 0, 65536, 720896);
    dir_tab[4]  = mk_row(0, CFG_DIST, 32'd32768, 0, 0, 0, 0, 0);
    dir_tab[5]  = mk_row(0, CFG_DIST, 32'd327680, 0, 0, 0, 0, 0);
    dir_tab[6]  = mk_row(0, CFG_DIST, 32'd688128, 0, 0, 0, 0, 0);
    dir_tab[7]  = mk_row(0, CFG_DIST, 32'd720896, 1, 655360, 0, 0, 720896);
    dir_tab[8]  = mk_row(0, CFG_DIST, 32'hFFFF_FFFF, 1, 655360, 0, 0, 720896);
    dir_tab[9]  = mk_row(1, CFG_BAD, 32'd12345, 0, 0, 0, 0, 0);
    dir_tab[10] = mk_row(0, CFG_DIST, 32'd400000, 0, 0, 0, 0, 0);
    dir_tab[11] = mk_row(1, CFG_VEL, 32'd0, 0, 0, 0, 0, 0);
    dir_tab[12] = mk_row(0, CFG_DIST, 32'd100, 1, 655360, 0, 0, 0);
    dir_tab[13] = mk_row(1, CFG_VEL, 32'h7FFF_FFFF, 0, 0, 0, 0, 0);
    dir_tab[14] = mk_row(1, CFG_ACC, 32'd1, 0, 0, 0, 0, 0);
    dir_tab[15] = mk_row(1, CFG_DIST, 32'h7FFF_FFFF, 0, 0, 0, 0, 0);
    dir_tab[16] = mk_row(0, CFG_DIST, 32'd0, 0, 0, 0, 0, 0);
    dir_tab[17] = mk_row(0, CFG_DIST, 32'hFFFF_FFFF, 0, 0, 0, 0, 0);
    dir_tab[18] = mk_row(0, CFG_DIST, 32'h8000_0000, 0, 0, 0, 0, 0);
    dir_tab[19] = mk_row(1, CFG_VEL, 32'd1, 0, 0, 0, 0, 0);
    dir_tab[20] = mk_row(1, CFG_ACC, 32'h7FFF_FFFF, 0, 0, 0, 0, 0);
    dir_tab[21] = mk_row(0, CFG_DIST, 32'h0001_2345, 0, 0, 0, 0, 0);
    dir_tab[22] = mk_row(0, CFG_DIST, 32'hFFFF_FFFF, 0, 0, 0, 0, 0);
    dir_tab[23] = mk_row(1, CFG_ACC, 32'd0, 0, 0, 0, 0, 0);
    dir_tab[24] = mk_row(0, CFG_DIST, 32'd5, 1, 64'h7FFF_FFFF, 0, 0, 0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[k]) begin
      if (dir_tab[k].is_cfg) begin
        write_reg(dir_tab[k].idx, dir_tab[k].val);
      end else begin
        use_typed = dir_tab[k].typed;
        typed_want = dir_tab[k].want;
        send_query(dir_tab[k].val);
      end
    end
    use_typed = 1'b0;

    for (int ph = 0; ph < N_PHASES; ph++) begin
      write_reg(CFG_DIST, {1'b0, pick_reg(1'b0)});
      write_reg(CFG_VEL, {1'b0, pick_reg(ph != 0)});
      write_reg(CFG_ACC, {1'b0, pick_reg(ph != 0)});
      calm = (ph == 4);
      if (ph == 2) hold_req = 1'b1;
      prof = eval_profile(64'd0);
      span = {32'd0, prof.total_duration};
      span = span + span / 8 + 1;
      if (span > DUR_MAX) span = DUR_MAX;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 4) == 0) t = $urandom;
        else t = $urandom_range(0, span[31:0]);
        send_query(t);
      end
    end
    s_axis_tvalid <= 1'b0;
    calm = 1'b0;

    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/tpe_pkg.sv
hdl/tpe_derive.sv
hdl/tpe_eval.sv
hdl/trapezoidal_profile_eval.sv
bench/tb_trapezoidal_profile_eval.sv
